@@ design/cspc_pkg.sv @@
// Shared constants for the correlation-sum pair counter: field widths, codes, defaults.
package cspc_pkg;

   // Default capacity of the point store.
   localparam int MAX_POINTS_DEF = 1024;
   localparam int MAX_DIMS_DEF   = 16;

   // Fixed field widths.
   localparam int CFG_N_W   = 11;
   localparam int CFG_D_W   = 5;
   localparam int COORD_W   = 16;
   localparam int RADIUS_W  = 36;
   localparam int COUNT_W   = 19;
   localparam int SQ_W      = 32;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_IN_USE = 1'b1;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Stream payload widths.
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;

endpackage

@@ design/correlation_sum_pair_counter.sv @@
// Top level of the correlation-sum pair counter: point store, pair walker and MAC pipeline.
//
// Loads one Q8.8 coordinate per load item into a point store (point-major, coordinate c
// of point p at p*d + c) and answers query items with the number of unordered point pairs
// whose squared Euclidean distance is at most the given Q20.16 squared radius, along with
// the total pair count n(n-1)/2. Loads past capacity are dropped and restart rewinds the
// write pointer. A query on a loaded set passes through setup (ST_PREP, ST_CHECK), the pair
// walk, then drain and handoff (ST_DRAIN, ST_DONE): the walker reads one coordinate of each
// point of a pair through the two read ports of the store each cycle and feeds one squaring
// MAC. A query on an incompletely loaded set (fewer than n*d coordinates since the last
// restart), or with fewer than two points, skips the walk and returns a zero count (with the
// incomplete flag in rsp_tuser where it applies). In either case the input is ready again
// in the same cycle as the result appears. The input side takes a new item only while no
// query is in progress; a finished result waits in the output register while loads and the
// next query are accepted, and a second result stalls the input until the first is taken.
// The store needs no clearing after reset.
// Configuration writes are meant only while idle.
module correlation_sum_pair_counter #(
   parameter int MAX_POINTS = cspc_pkg::MAX_POINTS_DEF,
   parameter int MAX_DIMS   = cspc_pkg::MAX_DIMS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: coord_value[15:0], radius_squared[51:16], zero fill
   input  logic [cspc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: req_type[0], restart[1]
   input  logic [cspc_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: pair_count[18:0], pair_total[37:19], zero fill
   output logic [cspc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // rsp_tuser: incomplete[0]
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cspc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cspc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import cspc_pkg::*;

   localparam int DEPTH   = MAX_POINTS * MAX_DIMS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int WP_W    = $clog2(DEPTH + 1);
   localparam int D_W     = $clog2(MAX_DIMS + 1);
   localparam int NEED_W  = CFG_N_W + D_W;
   localparam int CMP_W   = (WP_W > NEED_W) ? WP_W : NEED_W;
   localparam int DIST_W  = SQ_W + $clog2(MAX_DIMS);
   localparam int DCMP_W  = (DIST_W > RADIUS_W) ? DIST_W : RADIUS_W;
   localparam int PROD_W  = 2 * CFG_N_W;

   // Sequencer codes.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // Item fields.
   logic                req_type;
   logic                req_restart;
   logic [COORD_W-1:0]  req_coord;
   logic [RADIUS_W-1:0] req_radius;

   assign req_type    = req_tuser[0];
   assign req_restart = req_tuser[1];
   assign req_coord   = req_tdata[COORD_W-1:0];
   assign req_radius  = req_tdata[COORD_W +: RADIUS_W];

   // Configuration registers.
   logic [CFG_N_W-1:0] point_count_ff, point_count_in;
   logic [CFG_D_W-1:0] dims_ff, dims_in;

   assign csr_ready = 1'b1;

   always_comb begin
      point_count_in = point_count_ff;
      dims_in        = dims_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POINT_COUNT: point_count_in = csr_wdata;
            CSR_DIMS_IN_USE: dims_in        = csr_wdata[CFG_D_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective point count and dimension after saturation.
   logic [CFG_N_W-1:0] n_eff;
   logic [D_W-1:0]     d_eff;
   logic [ADDR_W-1:0]  d_addr;

   always_comb begin
      n_eff = (int'(point_count_ff) > MAX_POINTS) ? CFG_N_W'(MAX_POINTS) : point_count_ff;
      if (dims_ff == '0) begin
         d_eff = D_W'(1);
      end else if (int'(dims_ff) > MAX_DIMS) begin
         d_eff = D_W'(MAX_DIMS);
      end else begin
         d_eff = D_W'(dims_ff);
      end
   end

   assign d_addr = ADDR_W'(d_eff);

   // Handshakes.
   logic [2:0] state_ff, state_in;
   logic       req_fire;
   logic       load_fire;
   logic       query_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_type == REQ_LOAD);
   assign query_fire = req_fire && (req_type == REQ_QUERY);

   // Write pointer and store write.
   logic [WP_W-1:0] wp_ff, wp_in;
   logic [WP_W-1:0] wp_base;
   logic            st_wr_en;

   always_comb begin
      wp_base  = req_restart ? '0 : wp_ff;
      wp_in    = wp_ff;
      st_wr_en = 1'b0;
      if (load_fire) begin
         wp_in = wp_base;
         if (wp_base < WP_W'(DEPTH)) begin
            st_wr_en = 1'b1;
            wp_in    = wp_base + WP_W'(1);
         end
      end
   end

   // Pair walker.
   logic [CFG_N_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [ADDR_W-1:0]   base_i_ff, base_i_in, base_j_ff, base_j_in;
   logic [D_W-1:0]      c_ff, c_in;
   logic                issue;
   logic                last_c;
   logic                last_j;
   logic                last_pair;
   logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;

   assign issue     = (state_ff == ST_RUN);
   assign last_c    = (c_ff == d_eff - D_W'(1));
   assign last_j    = (j_ff == n_eff - CFG_N_W'(1));
   assign last_pair = last_j && (i_ff == n_eff - CFG_N_W'(2));
   assign rd_addr_a = base_i_ff + ADDR_W'(c_ff);
   assign rd_addr_b = base_j_ff + ADDR_W'(c_ff);

   // Query bookkeeping.
   logic [RADIUS_W-1:0] r2_ff, r2_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic                inc_ff, inc_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0]   pair_prod;
   logic                few_points;

   assign few_points = (n_eff < CFG_N_W'(2));
   assign pair_prod  = PROD_W'(n_eff) * PROD_W'(n_eff - CFG_N_W'(1));

   // MAC pipeline.
   logic [COORD_W-1:0]  rd_data_a, rd_data_b;
   logic                s1_valid_ff, s1_first_ff, s1_lastc_ff, s1_done_ff;
   logic                s2_valid_ff, s2_first_ff, s2_lastc_ff, s2_done_ff;
   logic [SQ_W-1:0]     s2_sq_ff, s2_sq_in;
   logic signed [COORD_W:0]     diff;
   logic signed [2*COORD_W+1:0] sq_full;
   logic [DIST_W-1:0]   acc_ff, acc_in;
   logic [DIST_W-1:0]   dist_sum;
   logic                hit;

   assign diff     = $signed({rd_data_a[COORD_W-1], rd_data_a})
                   - $signed({rd_data_b[COORD_W-1], rd_data_b});
   assign sq_full  = diff * diff;
   assign s2_sq_in = sq_full[SQ_W-1:0];
   assign dist_sum = (s2_first_ff ? '0 : acc_ff) + DIST_W'(s2_sq_ff);
   assign acc_in   = s2_valid_ff ? dist_sum : acc_ff;
   assign hit      = (DCMP_W'(dist_sum) <= DCMP_W'(r2_ff));

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [COUNT_W-1:0] rsp_total_ff, rsp_total_in;
   logic               rsp_inc_ff, rsp_inc_in;
   logic               rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Sequencer: prepare totals, check completeness, walk pairs, drain, deliver.
   always_comb begin
      state_in     = state_ff;
      r2_in        = r2_ff;
      total_in     = total_ff;
      need_in      = need_ff;
      inc_in       = inc_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      base_i_in    = base_i_ff;
      base_j_in    = base_j_ff;
      c_in         = c_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      rsp_total_in = rsp_total_ff;
      rsp_inc_in   = rsp_inc_ff;

      // Count each pair whose summed distance stays within the radius.
      if (s2_valid_ff && s2_lastc_ff && hit) begin
         cnt_in = cnt_ff + COUNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               r2_in    = req_radius;
               cnt_in   = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            total_in = few_points ? '0 : pair_prod[COUNT_W:1];
            need_in  = NEED_W'(n_eff) * NEED_W'(d_eff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            inc_in    = (CMP_W'(wp_ff) < CMP_W'(need_ff));
            i_in      = '0;
            j_in      = CFG_N_W'(1);
            base_i_in = '0;
            base_j_in = d_addr;
            c_in      = '0;
            if (inc_in || few_points) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // Advance coordinate, then partner point, then anchor point.
            if (!last_c) begin
               c_in = c_ff + D_W'(1);
            end else begin
               c_in = '0;
               if (last_pair) begin
                  state_in = ST_DRAIN;
               end else if (!last_j) begin
                  j_in      = j_ff + CFG_N_W'(1);
                  base_j_in = base_j_ff + d_addr;
               end else begin
                  i_in      = i_ff + CFG_N_W'(1);
                  j_in      = i_ff + CFG_N_W'(2);
                  base_i_in = base_i_ff + d_addr;
                  base_j_in = base_i_ff + d_addr + d_addr;
               end
            end
         end
         ST_DRAIN: begin
            if (s2_valid_ff && s2_done_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold the result until the output register is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = inc_ff ? '0 : cnt_ff;
               rsp_total_in = total_ff;
               rsp_inc_in   = inc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= CFG_N_W'(2);
         dims_ff        <= CFG_D_W'(1);
         wp_ff          <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         dims_ff        <= dims_in;
         wp_ff          <= wp_in;
         s1_valid_ff    <= issue;
         s2_valid_ff    <= s1_valid_ff;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      r2_ff        <= r2_in;
      total_ff     <= total_in;
      need_ff      <= need_in;
      inc_ff       <= inc_in;
      cnt_ff       <= cnt_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      base_i_ff    <= base_i_in;
      base_j_ff    <= base_j_in;
      c_ff         <= c_in;
      s1_first_ff  <= (c_ff == '0);
      s1_lastc_ff  <= last_c;
      s1_done_ff   <= last_c && last_pair;
      s2_first_ff  <= s1_first_ff;
      s2_lastc_ff  <= s1_lastc_ff;
      s2_done_ff   <= s1_done_ff;
      s2_sq_ff     <= s2_sq_in;
      acc_ff       <= acc_in;
      rsp_count_ff <= rsp_count_in;
      rsp_total_ff <= rsp_total_in;
      rsp_inc_ff   <= rsp_inc_in;
   end

   // Point store. Loads and pair reads never overlap, since loads are taken only when idle.
   cspc_ram #(
      .WIDTH (COORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (st_wr_en),
      .wr_addr   (wp_base[ADDR_W-1:0]),
      .wr_data   (req_coord),
      .rd_en     (issue),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - 2 * COUNT_W)'(0), rsp_total_ff, rsp_count_ff};
   assign rsp_tuser  = rsp_inc_ff;

`ifndef SYNTHESIS
   a_wp_in_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= WP_W'(DEPTH))
      else $error("write pointer beyond store depth");

   a_anchor_below_partner: assert property (@(posedge clock) disable iff (reset)
      issue |-> (base_i_ff < base_j_ff))
      else $error("pair walker read a point against itself or out of order");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("MAC pipeline busy while idle");

   a_last_pair_done: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_done_ff) |=> (state_ff == ST_DONE))
      else $error("last pair did not finish the query");

   a_incomplete_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_inc_ff) |-> (rsp_count_ff == '0))
      else $error("nonzero count on an incomplete set");
`endif

endmodule

@@ design/cspc_ram.sv @@
// Generic synchronous RAM: one write port, two registered read ports.
module cspc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule
